// ----- sv/rmv_pkg.sv -----
// rmv_pkg: widths, constants, sequencer states and shared-unit structs
// for the running mean / variance block
// no dependencies
package rmv_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_COUNT   = 65535;

	localparam int IN_W   = 16;
	localparam int CNT_W  = 16;
	localparam int MEAN_W = 24;
	localparam int SQ_W   = 46;
	localparam int VAR_W  = 31;
	localparam int STD_W  = 16;
	localparam int PROD_W = 2 * MEAN_W;
	localparam int REM_W  = STD_W + 3;
	localparam int STEP_W = 6;

	localparam logic [SQ_W-1:0]   SQ_MAX  = '1;
	localparam logic [SQ_W-1:0]   VAR_CAP = SQ_W'(1) << 30;
	localparam logic [STEP_W-1:0] MDIV_LAST = STEP_W'(MEAN_W - 1);
	localparam logic [STEP_W-1:0] VDIV_LAST = STEP_W'(SQ_W - 1);
	localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(STD_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MDIV,
		ST_MUL,
		ST_ACC,
		ST_VSET,
		ST_VDIV,
		ST_SQRT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [REM_W-1:0] a;
		logic [REM_W-1:0] b;
	} cs_req_t;

	typedef struct packed {
		logic [REM_W-1:0] diff;
		logic             ge;
	} cs_rsp_t;

endpackage

// ----- sv/rmv_if.sv -----
// rmv_in_if / rmv_out_if: valid-ready channels for samples and results
// depends on rmv_pkg
interface rmv_in_if import rmv_pkg::*;;
	logic            valid;
	logic            ready;
	logic [IN_W-1:0] sample;
	logic            restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink (input valid, input sample, input restart, output ready);
endinterface

interface rmv_out_if import rmv_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CNT_W-1:0]  sample_count;
	logic [MEAN_W-1:0] mean_value;
	logic [VAR_W-1:0]  variance_value;
	logic [STD_W-1:0]  std_deviation;
	logic              variance_valid;
	logic              overflow;

	modport source (output valid, output sample_count, output mean_value,
		output variance_value, output std_deviation, output variance_valid,
		output overflow, input ready);
	modport sink (input valid, input sample_count, input mean_value,
		input variance_value, input std_deviation, input variance_valid,
		input overflow, output ready);
endinterface

// ----- sv/rmv_cmp_sub.sv -----
// rmv_cmp_sub: shared compare-subtract unit, one divide or root step
// depends on rmv_pkg
module rmv_cmp_sub import rmv_pkg::*; (
	input  cs_req_t req,
	output cs_rsp_t rsp
);

	logic [REM_W:0] sub;

	assign sub      = {1'b0, req.a} - {1'b0, req.b};
	assign rsp.diff = sub[REM_W-1:0];
	assign rsp.ge   = ~sub[REM_W];

endmodule

// ----- sv/running_mean_variance_unit.sv -----
// running_mean_variance_unit: welford running mean / variance / std deviation
// depends on rmv_pkg, rmv_if, rmv_cmp_sub
//
// One item in, one result out. A new item is taken only once the last one is
// through, as the single compare-subtract unit runs a 24-step mean division,
// a 46-step variance division and a 16-step square root in turn (no mean
// division for a sample ignored at full count, no variance division or root
// below two samples). The result sits in an output register, so the next
// item can be taken while it waits to be read.
module running_mean_variance_unit import rmv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rmv_in_if.sink     samples,
	rmv_out_if.source  results
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [MEAN_W-1:0] mean_q;
	logic [SQ_W-1:0]   sq_q;

	logic [MEAN_W-1:0] x_q;
	logic [MEAN_W-1:0] mag_q;
	logic [MEAN_W-1:0] diff_q;
	logic              neg_q;
	logic              ovf_q;
	logic [PROD_W-1:0] prod_q;
	logic [SQ_W-1:0]   work_q;
	logic [REM_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [STD_W-1:0]  root_q;
	logic [STEP_W-1:0] step_q;
	logic [VAR_W-1:0]  var_q;
	logic [STD_W-1:0]  std_q;
	logic              vvalid_q;
	logic              out_vld_q;

	logic [CNT_W-1:0]  out_cnt_q;
	logic [MEAN_W-1:0] out_mean_q;
	logic [VAR_W-1:0]  out_var_q;
	logic [STD_W-1:0]  out_std_q;
	logic              out_vvalid_q;
	logic              out_ovf_q;

	logic [CNT_W-1:0]  cnt_eff;
	logic [MEAN_W-1:0] mean_eff;
	logic [MEAN_W-1:0] x_in;
	logic [MEAN_W-1:0] mag_in;
	logic              neg_in;
	logic              full;
	logic              accept;
	logic              load_out;
	logic              last_step;
	logic [MEAN_W-1:0] q_fin;
	logic [MEAN_W-1:0] new_mean;
	logic [SQ_W:0]     sq_sum;
	logic [SQ_W-1:0]   quot;
	logic [SQ_W-1:0]   var_cap;

	cs_req_t cs_req;
	cs_rsp_t cs_rsp;

	rmv_cmp_sub u_cs (
		.req (cs_req),
		.rsp (cs_rsp)
	);

	// input side
	always_comb begin
		cnt_eff  = samples.restart ? '0 : count_q;
		mean_eff = samples.restart ? '0 : mean_q;
		x_in     = MEAN_W'(samples.sample[SAMPLE_BITS-1:0]) << (MEAN_W - SAMPLE_BITS);
		neg_in   = x_in < mean_eff;
		mag_in   = neg_in ? (mean_eff - x_in) : (x_in - mean_eff);
		full     = (32'(cnt_eff) >= 32'(MAX_COUNT)) || (cnt_eff == '1);
	end

	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign load_out      = (state_q == ST_DONE) && (!out_vld_q || results.ready);

	// shared unit operands
	always_comb begin
		case (state_q)
			ST_SQRT: begin
				cs_req.a = {rem_q[REM_W-3:0], work_q[SQ_W-1:SQ_W-2]};
				cs_req.b = {1'b0, root_q, 2'b01};
			end
			default: begin
				cs_req.a = {2'b00, rem_q[CNT_W-1:0], work_q[SQ_W-1]};
				cs_req.b = {3'b000, div_q};
			end
		endcase
	end

	// step results
	always_comb begin
		q_fin    = {work_q[MEAN_W-2:0], cs_rsp.ge};
		new_mean = neg_q ? (mean_q - q_fin) : (mean_q + q_fin);
		sq_sum   = {1'b0, sq_q} + (SQ_W+1)'(prod_q[PROD_W-1:16]);
		quot     = {work_q[SQ_W-2:0], cs_rsp.ge};
		var_cap  = (quot > VAR_CAP) ? VAR_CAP : quot;
		case (state_q)
			ST_MDIV: last_step = (step_q == MDIV_LAST);
			ST_VDIV: last_step = (step_q == VDIV_LAST);
			ST_SQRT: last_step = (step_q == SQRT_LAST);
			default: last_step = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = full ? ST_VSET : ST_MDIV;
				end
			end
			ST_MDIV: begin
				if (last_step) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_ACC;
			ST_ACC:  state_d = ST_VSET;
			ST_VSET: state_d = (count_q >= CNT_W'(2)) ? ST_VDIV : ST_DONE;
			ST_VDIV: begin
				if (last_step) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (last_step) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// statistics and iteration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			mean_q   <= '0;
			sq_q     <= '0;
			step_q   <= '0;
			x_q      <= '0;
			mag_q    <= '0;
			diff_q   <= '0;
			neg_q    <= 1'b0;
			ovf_q    <= 1'b0;
			prod_q   <= '0;
			work_q   <= '0;
			rem_q    <= '0;
			div_q    <= '0;
			root_q   <= '0;
			var_q    <= '0;
			std_q    <= '0;
			vvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= cnt_eff;
						mean_q  <= mean_eff;
						sq_q    <= samples.restart ? '0 : sq_q;
						x_q     <= x_in;
						mag_q   <= mag_in;
						neg_q   <= neg_in;
						ovf_q   <= full;
						work_q  <= {mag_in, (SQ_W-MEAN_W)'(0)};
						rem_q   <= '0;
						div_q   <= cnt_eff + CNT_W'(1);
						step_q  <= '0;
					end
				end
				ST_MDIV: begin
					rem_q  <= cs_rsp.ge ? cs_rsp.diff : cs_req.a;
					work_q <= {work_q[SQ_W-2:0], cs_rsp.ge};
					step_q <= last_step ? '0 : step_q + STEP_W'(1);
					if (last_step) begin
						mean_q  <= new_mean;
						count_q <= count_q + CNT_W'(1);
						diff_q  <= neg_q ? (new_mean - x_q) : (x_q - new_mean);
					end
				end
				ST_MUL: begin
					prod_q <= PROD_W'(mag_q) * PROD_W'(diff_q);
				end
				ST_ACC: begin
					sq_q <= sq_sum[SQ_W] ? SQ_MAX : sq_sum[SQ_W-1:0];
				end
				ST_VSET: begin
					work_q   <= sq_q;
					rem_q    <= '0;
					div_q    <= count_q - CNT_W'(1);
					step_q   <= '0;
					var_q    <= '0;
					std_q    <= '0;
					vvalid_q <= (count_q >= CNT_W'(2));
				end
				ST_VDIV: begin
					step_q <= last_step ? '0 : step_q + STEP_W'(1);
					if (last_step) begin
						var_q  <= var_cap[VAR_W-1:0];
						work_q <= {1'b0, var_cap[VAR_W-1:0], (SQ_W-VAR_W-1)'(0)};
						rem_q  <= '0;
						root_q <= '0;
					end else begin
						rem_q  <= cs_rsp.ge ? cs_rsp.diff : cs_req.a;
						work_q <= quot;
					end
				end
				ST_SQRT: begin
					rem_q  <= cs_rsp.ge ? cs_rsp.diff : cs_req.a;
					work_q <= {work_q[SQ_W-3:0], 2'b00};
					root_q <= {root_q[STD_W-2:0], cs_rsp.ge};
					step_q <= last_step ? '0 : step_q + STEP_W'(1);
					if (last_step) begin
						std_q <= {root_q[STD_W-2:0], cs_rsp.ge};
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q    <= 1'b0;
			out_cnt_q    <= '0;
			out_mean_q   <= '0;
			out_var_q    <= '0;
			out_std_q    <= '0;
			out_vvalid_q <= 1'b0;
			out_ovf_q    <= 1'b0;
		end else if (load_out) begin
			out_vld_q    <= 1'b1;
			out_cnt_q    <= count_q;
			out_mean_q   <= mean_q;
			out_var_q    <= var_q;
			out_std_q    <= std_q;
			out_vvalid_q <= vvalid_q;
			out_ovf_q    <= ovf_q;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign results.valid          = out_vld_q;
	assign results.sample_count   = out_cnt_q;
	assign results.mean_value     = out_mean_q;
	assign results.variance_value = out_var_q;
	assign results.std_deviation  = out_std_q;
	assign results.variance_valid = out_vvalid_q;
	assign results.overflow       = out_ovf_q;

endmodule

// ----- verif/running_mean_variance_unit_tb.sv -----
`timescale 1ns / 100ps
// running_mean_variance_unit_tb: directed and random-run checks of the
// welford statistics block against a predictor kept in the bench
// depends on rmv_pkg, rmv_if and running_mean_variance_unit
module running_mean_variance_unit_tb;
	import rmv_pkg::*;

	typedef struct packed {
		logic [CNT_W-1:0]  sample_count;
		logic [MEAN_W-1:0] mean_value;
		logic [VAR_W-1:0]  variance_value;
		logic [STD_W-1:0]  std_deviation;
		logic              variance_valid;
		logic              overflow;
	} stats_t;

	typedef enum int {
		MIX_UNIFORM,
		MIX_CLUSTER,
		MIX_EXTREME,
		MIX_CONSTANT
	} sample_mix_t;

	localparam int IDLE_PCT    = 28;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 200;

	logic clk = 1'b0;
	logic arst_n;

	rmv_in_if  sample_ch ();
	rmv_out_if result_ch ();

	running_mean_variance_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.results (result_ch)
	);

	always #5 clk = ~clk;

	logic [CNT_W-1:0]  n_seen   = '0;
	logic [MEAN_W-1:0] run_mean = '0;
	logic [SQ_W-1:0]   m2_sum   = '0;

	stats_t expected_q[$];
	bit     idle_on;
	int     items_sent;
	int     results_checked  = 0;
	int     full_count_hits  = 0;
	int     capped_variances = 0;
	int     errors           = 0;
	int     stall_cycles     = 0;

	function automatic stats_t welford_update(input logic [IN_W-1:0] s, input logic restart);
		stats_t r;
		longint x, delta, nm;
		longint unsigned n, mag, quot, spread, prod, vq, t, root;
		r = '0;
		if (restart) begin
			n_seen = '0;
			run_mean = '0;
			m2_sum = '0;
		end
		if (n_seen >= MAX_COUNT) begin
			r.overflow = 1'b1;
		end else begin
			n = n_seen + 1;
			x = longint'(s[SAMPLE_BITS-1:0]) << (MEAN_W - SAMPLE_BITS);
			delta = x - longint'(run_mean);
			mag = (delta < 0) ? -delta : delta;
			quot = mag / n;
			nm = (delta < 0) ? longint'(run_mean) - longint'(quot)
				: longint'(run_mean) + longint'(quot);
			spread = (delta < 0) ? nm - x : x - nm;
			prod = (mag * spread) >> 16;
			n_seen = n[CNT_W-1:0];
			run_mean = nm[MEAN_W-1:0];
			if (prod > 64'(SQ_MAX - m2_sum))
				m2_sum = SQ_MAX;
			else
				m2_sum = m2_sum + prod[SQ_W-1:0];
		end
		r.sample_count = n_seen;
		r.mean_value = run_mean;
		if (n_seen >= 2) begin
			vq = 64'(m2_sum) / 64'(n_seen - 16'd1);
			if (vq > 64'(VAR_CAP))
				vq = 64'(VAR_CAP);
			root = 0;
			for (int b = STD_W - 1; b >= 0; b--) begin
				t = root | (64'd1 << b);
				if (t * t <= vq)
					root = t;
			end
			r.variance_value = vq[VAR_W-1:0];
			r.std_deviation = root[STD_W-1:0];
			r.variance_valid = 1'b1;
		end
		return r;
	endfunction

	task automatic send_item(input logic [IN_W-1:0] s, input logic restart);
		stats_t want;
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= s;
		sample_ch.restart <= restart;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		want = welford_update(s, restart);
		expected_q = {expected_q, want};
		items_sent++;
	endtask

	// first items run from the reset state without a restart
	task automatic test_directed();
		idle_on = 1'b1;
		send_item(16'h0000, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h8000, 1'b0);
		send_item(16'hFFFF, 1'b1);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h0000, 1'b0);
		send_item(16'h0001, 1'b1);
		send_item(16'h0002, 1'b0);
		send_item(16'hAAAA, 1'b0);
		send_item(16'h5555, 1'b0);
		send_item(16'h8000, 1'b1);
		send_item(16'h7FFF, 1'b0);
		send_item(16'h8001, 1'b0);
		send_item(16'h0000, 1'b1);
		send_item(16'h0000, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h1234, 1'b1);
		send_item(16'hFFFE, 1'b0);
		send_item(16'h0001, 1'b0);
	endtask

	task automatic test_random_runs(input int n_items, input bit idling);
		int sent;
		int run_len;
		sample_mix_t mix;
		logic [IN_W-1:0] base;
		logic [IN_W-1:0] s;
		logic rs;
		idle_on = idling;
		sent = 0;
		while (sent < n_items) begin
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
				: $urandom_range(1, 16);
			mix = sample_mix_t'($urandom_range(0, 3));
			base = IN_W'($urandom_range(0, 65535));
			for (int k = 0; k < run_len && sent < n_items; k++) begin
				case (mix)
				MIX_UNIFORM: s = IN_W'($urandom_range(0, 65535));
				MIX_CLUSTER: s = base + IN_W'($urandom_range(0, 1 << $urandom_range(0, 8)));
				MIX_EXTREME: s = $urandom_range(0, 1) ? IN_W'(16'hFFFF - $urandom_range(0, 3))
					: IN_W'($urandom_range(0, 3));
				default: s = base;
				endcase
				rs = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
				send_item(s, rs);
				sent++;
			end
		end
	endtask

	always @(posedge clk)
		result_ch.ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);

	always @(posedge clk) begin
		stats_t got;
		stats_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.sample_count = result_ch.sample_count;
			got.mean_value = result_ch.mean_value;
			got.variance_value = result_ch.variance_value;
			got.std_deviation = result_ch.std_deviation;
			got.variance_valid = result_ch.variance_valid;
			got.overflow = result_ch.overflow;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected item: cnt=%0d mean=%h var=%h sd=%h vv=%b ovf=%b",
						got.sample_count, got.mean_value, got.variance_value,
						got.std_deviation, got.variance_valid, got.overflow);
			end else begin
				want = expected_q.pop_front();
				results_checked++;
				if (want.overflow)
					full_count_hits++;
				if (want.variance_value == VAR_W'(VAR_CAP))
					capped_variances++;
				if (got !== want) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch on item %0d", results_checked);
						$display("  expected cnt=%0d mean=%h var=%h sd=%h vv=%b ovf=%b",
							want.sample_count, want.mean_value, want.variance_value,
							want.std_deviation, want.variance_valid, want.overflow);
						$display("  actual   cnt=%0d mean=%h var=%h sd=%h vv=%b ovf=%b",
							got.sample_count, got.mean_value, got.variance_value,
							got.std_deviation, got.variance_valid, got.overflow);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.sample <= '0;
		sample_ch.restart <= 1'b0;
		idle_on = 1'b1;
		items_sent = 0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_runs(1200, 1'b1);
		test_random_runs(300, 1'b0);
		test_random_runs(100, 1'b1);
		sample_ch.valid <= 1'b0;
		idle_on = 1'b1;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT)
			@(posedge clk);
		$display("sent %0d items, checked %0d results, %0d errors",
			items_sent, results_checked, errors);
		$display("covered %0d ignored samples at full count and %0d capped variances",
			full_count_hits, capped_variances);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
